@@ rtl/lfu_slot_replacement_defines.svh @@
// Assertion macros shared by the LFU slot replacement RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LFU_SLOT_REPLACEMENT_DEFINES_SVH
`define LFU_SLOT_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LFUSR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LFUSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lfusr_pkg.sv @@
// Constants and types for the LFU slot replacement block.
// Depends on nothing; used by lfu_slot_replacement.
`timescale 1ns / 1ps
`default_nettype none

package lfusr_pkg;

   localparam int BIN_WIDTH  = 7;
   localparam int NUM_BINS   = 1 << BIN_WIDTH;
   localparam int NUM_SLOTS  = 4;
   localparam int COUNT_BITS = 16;
   localparam int SLOT_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int FILL_BITS  = $clog2(NUM_SLOTS + 1);
   localparam int OUT_SLOT_BITS = 2;

   typedef logic [BIN_WIDTH-1:0]  bin_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [FILL_BITS-1:0]  fill_type;

   localparam count_type COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam fill_type  FILL_FULL = FILL_BITS'(NUM_SLOTS);

endpackage

`default_nettype wire

@@ rtl/lfu_slot_replacement.sv @@
// LFU slot replacement: request counting table plus a small set of slots.
// Depends on lfusr_pkg and lfu_slot_replacement_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "lfu_slot_replacement_defines.svh"

// Channel  Ports                                               Direction
// req      req_valid, req_stall, req_bin_number                in  (bin requested)
// rsp      rsp_valid, rsp_stall, rsp_hit, rsp_slot_used,       out (one item per req)
//          rsp_evicted_valid, rsp_evicted_bin
//
// Throughput is one item per cycle unless rsp stalls; rsp_valid is registered.
// The count table read is the pacing element: one read at accept, one write on advance.
// Reset clears all request counts at once through per-bin valid bits; no clearing pass.
// A stall on rsp holds the result register, then the working stage, then req.
module lfu_slot_replacement (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [lfusr_pkg::BIN_WIDTH-1:0]     req_bin_number,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_hit,
   output logic [lfusr_pkg::OUT_SLOT_BITS-1:0]      rsp_slot_used,
   output logic                                     rsp_evicted_valid,
   output logic [lfusr_pkg::BIN_WIDTH-1:0]          rsp_evicted_bin
);

   // Handshake and flow control
   logic accept;
   logic advance;
   logic s1_valid_ff, s1_valid_in;
   lfusr_pkg::bin_type s1_bin_ff;

   // Count table: memory plus per-bin valid bits (cleared entry reads as zero)
   lfusr_pkg::count_type count_mem [lfusr_pkg::NUM_BINS];
   logic [lfusr_pkg::NUM_BINS-1:0] count_vld_ff;
   lfusr_pkg::count_type rd_raw_ff;
   logic rd_vld_ff;
   logic fwd_ff;
   lfusr_pkg::count_type fwd_data_ff;
   lfusr_pkg::count_type cur_count;
   lfusr_pkg::count_type new_count;

   // Slots: resident bin and a shadow copy of its request count
   lfusr_pkg::bin_type   slot_bin_ff   [lfusr_pkg::NUM_SLOTS];
   lfusr_pkg::count_type slot_count_ff [lfusr_pkg::NUM_SLOTS];
   lfusr_pkg::fill_type  slots_filled_ff, slots_filled_in;

   // Decision logic
   logic [lfusr_pkg::NUM_SLOTS-1:0] hit_vec;
   logic hit_any;
   logic full;
   lfusr_pkg::slot_type hit_slot;
   lfusr_pkg::slot_type victim;
   lfusr_pkg::count_type victim_count;
   lfusr_pkg::bin_type victim_bin;
   lfusr_pkg::slot_type target;
   logic evict;

   // Result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff;
   logic [lfusr_pkg::OUT_SLOT_BITS-1:0] rsp_slot_ff;
   logic rsp_evicted_valid_ff;
   lfusr_pkg::bin_type rsp_evicted_bin_ff;

   // Advance the working stage when the result register is free or draining.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_bin_ff <= req_bin_number;
      end
   end

   // Count table memory: read at accept, write back on advance.
   always_ff @(posedge clock) begin
      if (advance) begin
         count_mem[s1_bin_ff] <= new_count;
      end
      if (accept) begin
         rd_raw_ff <= count_mem[req_bin_number];
      end
   end

   // Valid bits clear the whole table at once on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_vld_ff <= '0;
      end else if (advance) begin
         count_vld_ff[s1_bin_ff] <= 1'b1;
      end
   end

   // Forward a write that lands in the same cycle as the read of that bin.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_vld_ff   <= count_vld_ff[req_bin_number];
         fwd_ff      <= advance && (s1_bin_ff == req_bin_number);
         fwd_data_ff <= new_count;
      end
   end

   always_comb begin
      if (fwd_ff) begin
         cur_count = fwd_data_ff;
      end else if (rd_vld_ff) begin
         cur_count = rd_raw_ff;
      end else begin
         cur_count = '0;
      end
      // Saturate at the largest count.
      new_count = (cur_count == lfusr_pkg::COUNT_MAX) ? cur_count : cur_count + 1'b1;
   end

   // Hit search over the filled slots, lowest slot first.
   always_comb begin
      hit_slot = '0;
      for (int s = 0; s < lfusr_pkg::NUM_SLOTS; s++) begin
         hit_vec[s] = (lfusr_pkg::FILL_BITS'(s) < slots_filled_ff) &&
                      (slot_bin_ff[s] == s1_bin_ff);
      end
      for (int s = lfusr_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
         if (hit_vec[s]) begin
            hit_slot = lfusr_pkg::SLOT_BITS'(s);
         end
      end
      hit_any = |hit_vec;
      full    = (slots_filled_ff == lfusr_pkg::FILL_FULL);
   end

   // Victim: fewest requests, ties to the lower bin number.
   always_comb begin
      victim       = '0;
      victim_count = slot_count_ff[0];
      victim_bin   = slot_bin_ff[0];
      for (int s = 1; s < lfusr_pkg::NUM_SLOTS; s++) begin
         if ((slot_count_ff[s] < victim_count) ||
             ((slot_count_ff[s] == victim_count) && (slot_bin_ff[s] < victim_bin))) begin
            victim       = lfusr_pkg::SLOT_BITS'(s);
            victim_count = slot_count_ff[s];
            victim_bin   = slot_bin_ff[s];
         end
      end
   end

   always_comb begin
      evict = !hit_any && full;
      if (hit_any) begin
         target = hit_slot;
      end else if (!full) begin
         target = slots_filled_ff[lfusr_pkg::SLOT_BITS-1:0];
      end else begin
         target = victim;
      end
      slots_filled_in = slots_filled_ff;
      if (advance && !hit_any && !full) begin
         slots_filled_in = slots_filled_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_filled_ff <= '0;
      end else begin
         slots_filled_ff <= slots_filled_in;
      end
   end

   // Keep the resident count copy in step with the table.
   always_ff @(posedge clock) begin
      if (advance) begin
         slot_count_ff[target] <= new_count;
         if (!hit_any) begin
            slot_bin_ff[target] <= s1_bin_ff;
         end
      end
   end

   // Result register: load on advance, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff           <= hit_any;
         rsp_slot_ff          <= lfusr_pkg::OUT_SLOT_BITS'(target);
         rsp_evicted_valid_ff <= evict;
         rsp_evicted_bin_ff   <= evict ? victim_bin : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_slot_used     = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_bin   = rsp_evicted_bin_ff;

   `LFUSR_ASSERT_IMPL(a_hit_unique, clock, reset, s1_valid_ff, $onehot0(hit_vec),
      "requested bin resident in more than one slot")
   `LFUSR_ASSERT_IMPL(a_evict_only_full, clock, reset, rsp_valid_ff && rsp_evicted_valid_ff,
      slots_filled_ff == lfusr_pkg::FILL_FULL, "eviction reported before all slots filled")
   `LFUSR_ASSERT_IMPL(a_hit_no_evict, clock, reset, rsp_valid_ff && rsp_hit_ff,
      !rsp_evicted_valid_ff && (rsp_evicted_bin_ff == '0), "hit reported with an eviction")
   `LFUSR_ASSERT_NEXT(a_fill_step, clock, reset, advance && !hit_any && !full,
      slots_filled_ff == $past(slots_filled_ff) + 1'b1, "slot fill count did not advance")

endmodule

`default_nettype wire

@@ dv/lfu_placement_checker.sv @@
// Checker for lfu_slot_replacement: mirrors the request counts and slot contents.
// It predicts hit, slot and eviction for every accepted request and compares them in order.
// Depends on lfusr_pkg for widths, types and the count ceiling.
`timescale 1ns / 1ps

module lfu_placement_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic [lfusr_pkg::BIN_WIDTH-1:0]     req_bin_number,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic                                rsp_hit,
   input  wire logic [lfusr_pkg::OUT_SLOT_BITS-1:0] rsp_slot_used,
   input  wire logic                                rsp_evicted_valid,
   input  wire logic [lfusr_pkg::BIN_WIDTH-1:0]     rsp_evicted_bin,
   output int                                       error_count,
   output int                                       pending,
   output int                                       accepted,
   output int                                       hits,
   output int                                       fills,
   output int                                       evictions
);

   typedef struct packed {
      lfusr_pkg::bin_type                  bin_number;
      logic                                hit;
      logic [lfusr_pkg::OUT_SLOT_BITS-1:0] slot;
      logic                                evicted_valid;
      lfusr_pkg::bin_type                  evicted_bin;
   } placement_type;

   lfusr_pkg::count_type freq_table [lfusr_pkg::NUM_BINS];
   lfusr_pkg::bin_type   slot_bin   [lfusr_pkg::NUM_SLOTS];
   int            slots_in_use;
   placement_type placement_fifo [$];
   placement_type head;
   int            mismatches;
   int            n_accepted, n_hits, n_fills, n_evictions;

   // Count the request, then place the bin: hit, fill the next empty slot, or
   // evict the resident with the fewest requests (lowest bin number on a tie).
   function automatic placement_type place_request(lfusr_pkg::bin_type b);
      placement_type p;
      int            victim;
      bit            found;
      p = '0;
      p.bin_number = b;
      found = 1'b0;
      if (freq_table[b] != lfusr_pkg::COUNT_MAX)
         freq_table[b] = freq_table[b] + 1'b1;
      for (int s = 0; s < slots_in_use; s++) begin
         if (!found && slot_bin[s] == b) begin
            found  = 1'b1;
            p.hit  = 1'b1;
            p.slot = lfusr_pkg::OUT_SLOT_BITS'(s);
         end
      end
      if (!found) begin
         if (slots_in_use < lfusr_pkg::NUM_SLOTS) begin
            slot_bin[slots_in_use] = b;
            p.slot = lfusr_pkg::OUT_SLOT_BITS'(slots_in_use);
            slots_in_use++;
         end else begin
            victim = 0;
            for (int s = 1; s < lfusr_pkg::NUM_SLOTS; s++) begin
               if (freq_table[slot_bin[s]] < freq_table[slot_bin[victim]] ||
                   (freq_table[slot_bin[s]] == freq_table[slot_bin[victim]] &&
                    slot_bin[s] < slot_bin[victim]))
                  victim = s;
            end
            p.evicted_valid  = 1'b1;
            p.evicted_bin    = slot_bin[victim];
            p.slot           = lfusr_pkg::OUT_SLOT_BITS'(victim);
            slot_bin[victim] = b;
         end
      end
      return p;
   endfunction

   task automatic log_mismatch(string what);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t ns: %s | got hit=%0d slot=%0d evicted_valid=%0d evicted_bin=%0d",
                  $time, what, rsp_hit, rsp_slot_used, rsp_evicted_valid,
                  rsp_evicted_bin);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (freq_table[i]) freq_table[i] = '0;
         foreach (slot_bin[i]) slot_bin[i] = '0;
         slots_in_use = 0;
         placement_fifo.delete();
         mismatches  = 0;
         n_accepted  = 0;
         n_hits      = 0;
         n_fills     = 0;
         n_evictions = 0;
      end else begin
         if (req_valid && !req_stall) begin
            head = place_request(req_bin_number);
            placement_fifo.push_back(head);
            n_accepted++;
            if (head.hit)
               n_hits++;
            else if (head.evicted_valid)
               n_evictions++;
            else
               n_fills++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (placement_fifo.size() == 0) begin
               log_mismatch("result with no request outstanding");
            end else begin
               head = placement_fifo.pop_front();
               if (rsp_hit !== head.hit || rsp_slot_used !== head.slot ||
                   rsp_evicted_valid !== head.evicted_valid ||
                   rsp_evicted_bin !== head.evicted_bin)
                  log_mismatch($sformatf(
                     "bin %0d: want hit=%0d slot=%0d evicted_valid=%0d evicted_bin=%0d",
                     head.bin_number, head.hit, head.slot, head.evicted_valid,
                     head.evicted_bin));
            end
         end
      end
      error_count <= mismatches;
      pending     <= placement_fifo.size();
      accepted    <= n_accepted;
      hits        <= n_hits;
      fills       <= n_fills;
      evictions   <= n_evictions;
   end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for lfu_slot_replacement: clock, reset, request stimulus, result stalls.
// Depends on lfusr_pkg, the RTL block and lfu_placement_checker, which does all checking.
// Runs a directed opening, then random working-set traffic, then a final drain.
`timescale 1ns / 1ps

module tb_top;

   // Stall patterns on the result side
   localparam int STALL_NONE   = 0;
   localparam int STALL_LIGHT  = 1;
   localparam int STALL_HEAVY  = 2;
   localparam int STALL_PERIOD = 3;

   localparam int RANDOM_ITEMS = 1330;
   localparam int CYCLE_LIMIT  = 200_000;

   logic                                clock          = 1'b0;
   logic                                reset          = 1'b1;
   logic                                req_valid      = 1'b0;
   logic                                req_stall;
   logic [lfusr_pkg::BIN_WIDTH-1:0]     req_bin_number = '0;
   logic                                rsp_valid;
   logic                                rsp_stall      = 1'b0;
   logic                                rsp_hit;
   logic [lfusr_pkg::OUT_SLOT_BITS-1:0] rsp_slot_used;
   logic                                rsp_evicted_valid;
   logic [lfusr_pkg::BIN_WIDTH-1:0]     rsp_evicted_bin;

   int error_count, pending, accepted, hits, fills, evictions;
   int cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lfu_slot_replacement dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_bin_number   (req_bin_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_slot_used    (rsp_slot_used),
      .rsp_evicted_valid(rsp_evicted_valid),
      .rsp_evicted_bin  (rsp_evicted_bin)
   );

   lfu_placement_checker placement_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_bin_number   (req_bin_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_slot_used    (rsp_slot_used),
      .rsp_evicted_valid(rsp_evicted_valid),
      .rsp_evicted_bin  (rsp_evicted_bin),
      .error_count      (error_count),
      .pending          (pending),
      .accepted         (accepted),
      .hits             (hits),
      .fills            (fills),
      .evictions        (evictions)
   );

   // Receiver: pick a stall pattern, hold it for a random stretch, then pick again.
   // STALL_NONE stretches give back-to-back acceptance; the others land stalls
   // on every pipeline phase.
   int stall_mode = STALL_NONE;
   int stall_left = 0;
   int stall_tick = 0;
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(STALL_NONE, STALL_PERIOD);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_tick++;
      if (reset)
         rsp_stall <= 1'b0;
      else case (stall_mode)
         STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
         STALL_PERIOD: rsp_stall <= (stall_tick % 5 < 2);
         default:      rsp_stall <= 1'b0;
      endcase
   end

   // Watchdog: bound the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("watchdog expired after %0d cycles with %0d results outstanding",
                  cycle_count, pending);
         $display("lfu_slot_replacement test failed");
         $finish;
      end
   end

   // Present one bin at a falling edge and hold it until accepted.
   // Return on the falling edge after acceptance so the caller may drive again.
   task automatic send_request(input lfusr_pkg::bin_type b);
      req_valid      <= 1'b1;
      req_bin_number <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drop valid and hold off until every outstanding result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Directed opening: fill all four slots, hit, tie-break evictions, and the
   // field extremes 0 and 127 plus alternating bit patterns.
   lfusr_pkg::bin_type opening [] = '{7'd0, 7'd127, 7'd0, 7'd85, 7'd42, 7'd100, 7'd100,
                                      7'd85, 7'd7, 7'd127, 7'd127, 7'd0, 7'd1, 7'd42,
                                      7'd85, 7'd126, 7'd64, 7'd63};

   lfusr_pkg::bin_type work_set [8];
   int                 work_size;
   int                 sent;
   int                 next_shuffle;
   int                 burst;
   lfusr_pkg::bin_type pick;

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (opening[i])
         send_request(opening[i]);
      // Pause the sender until the pipe is empty at least once
      drain();

      // Random part: mostly a small working set so the slots see hits and
      // LFU evictions among a few hot bins; the rest is uniform noise.
      sent         = 0;
      next_shuffle = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= next_shuffle) begin
            work_size = $urandom_range(3, 8);
            foreach (work_set[i])
               work_set[i] = lfusr_pkg::BIN_WIDTH'($urandom_range(0,
                                                                  lfusr_pkg::NUM_BINS - 1));
            next_shuffle = sent + $urandom_range(80, 250);
         end
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            if ($urandom_range(0, 9) < 8)
               pick = work_set[$urandom_range(0, work_size - 1)];
            else
               pick = lfusr_pkg::BIN_WIDTH'($urandom_range(0, lfusr_pkg::NUM_BINS - 1));
            send_request(pick);
            sent++;
         end
         // Gap between bursts; sometimes none, so bursts run back to back
         if ($urandom_range(0, 2) != 0) begin
            req_valid      <= 1'b0;
            req_bin_number <= lfusr_pkg::BIN_WIDTH'($urandom);
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end

      drain();
      repeat (8) @(posedge clock);

      $display("covered %0d requests: %0d hits, %0d slot fills, %0d evictions",
               accepted, hits, fills, evictions);
      $display("includes a directed opening and random working-set traffic under stalls");
      if (error_count == 0 && pending == 0)
         $display("lfu_slot_replacement test passed");
      else
         $display("lfu_slot_replacement test failed");
      $finish;
   end

endmodule
